/* rtl/bb3_pkg.sv */
// Shared types, constants and functions for the 3x3 box blur.
package bb3_pkg;

    localparam int MAX_SIZE  = 1024;
    localparam int SIZE_W    = 11;
    localparam int COL_W     = 10;
    localparam int CH_W      = 16;
    localparam int PIX_W     = 3 * CH_W;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;
    localparam int RSUM_W    = CH_W + 2;
    localparam int TSUM_W    = CH_W + 4;
    localparam int RECIP_W   = 25;
    localparam int RECIP_SH  = 24;
    localparam int PROD_W    = TSUM_W + RECIP_W;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic [8:0][PIX_W-1:0] px;
        logic [8:0]            mask;
        logic                  last;
    } bb3_item_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > SIZE_W'(MAX_SIZE)) begin
            r = SIZE_W'(MAX_SIZE);
        end
        return r;
    endfunction

    // ceil(2^24 / d); exact truncated quotient for sums below 2^20
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] d);
        logic [RECIP_W-1:0] r;
        case (d)
            4'd2:    r = RECIP_W'(8388608);
            4'd3:    r = RECIP_W'(5592406);
            4'd4:    r = RECIP_W'(4194304);
            4'd5:    r = RECIP_W'(3355444);
            4'd6:    r = RECIP_W'(2796203);
            4'd7:    r = RECIP_W'(2396746);
            4'd8:    r = RECIP_W'(2097152);
            4'd9:    r = RECIP_W'(1864136);
            default: r = RECIP_W'(16777216);
        endcase
        return r;
    endfunction

endpackage

/* rtl/box_blur_3x3_clamped.sv */
// Top level of the streaming 3x3 box blur with clamped borders.
// One word per clock in and out, sustained while m_tready stays high. A pixel's result
// leaves image_size + 1 words after it enters, so after a frame send image_size + 1 flush
// words (tuser high) to drain it; the last result carries m_tlast. Input passes a one-stage
// front end that reads the two line buffers (one read and one write port each), a
// four-deep queue, and a three-stage back end (row sums, total, reciprocal multiply);
// m_tvalid rises once the word that completes a result has passed all of them. Write
// image_size only while the stream is idle.
module box_blur_3x3_clamped import bb3_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,     // image_size
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [PIX_W-1:0]  s_tdata,       // in_red, in_green, in_blue
    input  logic              s_tuser,       // func
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [PIX_W-1:0]  m_tdata,       // out_red, out_green, out_blue
    output logic              m_tlast        // frame_end
);

    logic              acc, busy, push, pop, empty;
    bb3_item_t         push_data, head;
    logic [QCNT_W-1:0] count;

    assign s_tready = (count + QCNT_W'(busy)) < QCNT_W'(QDEPTH);
    assign acc      = s_tvalid && s_tready;

    bb3_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .acc       (acc),
        .func      (s_tuser),
        .pix_in    (s_tdata),
        .busy      (busy),
        .push      (push),
        .push_data (push_data)
    );

    bb3_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .count     (count)
    );

    bb3_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/bb3_front.sv */
// Front end: accepts stream words, tracks position, owns line buffers and window.
module bb3_front import bb3_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    input  logic              acc,
    input  logic              func,
    input  pix_t              pix_in,
    output logic              busy,
    output logic              push,
    output bb3_item_t         push_data
);

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SIZE_W-1:0] row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;

    logic              a_valid_reg;
    logic [COL_W-1:0]  a_idx_reg;
    pix_t              a_pix_reg;
    logic              a_col0_reg, a_emit_reg, a_last_reg;
    logic [8:0]        a_mask_reg;
    logic              a_fwd_reg;
    pix_t              fwd_top_reg, fwd_mid_reg;
    pix_t              up_q_reg, lo_q_reg;

    pix_t upper_mem [MAX_SIZE];
    pix_t lower_mem [MAX_SIZE];

    logic [8:0][PIX_W-1:0] win_reg, win_next;

    logic              proc, col0, emit, last, wrap;
    logic [SIZE_W+1:0] r_ext, n_ext, rr;
    logic [2:0]        row_ok, col_ok;
    logic [8:0]        mask;
    pix_t              eff_top, eff_mid;

    assign busy = a_valid_reg;

    always_comb begin
        r_ext = {2'b00, row_reg};
        n_ext = {2'b00, size_reg};
        proc  = acc && !(func && (row_reg < size_reg));
        col0  = (col_reg == '0);
        emit  = col0 ? (r_ext >= 13'd2 && r_ext < n_ext + 13'd2)
                     : (r_ext >= 13'd1 && r_ext < n_ext + 13'd1);
        last  = col0 && (r_ext == n_ext + 13'd1);
        for (int i = 0; i < 3; i++) begin
            rr = r_ext + 13'(i);
            row_ok[i] = col0 ? (rr >= 13'd3 && rr < n_ext + 13'd3)
                             : (rr >= 13'd2 && rr < n_ext + 13'd2);
        end
        col_ok = col0 ? {1'b1, (size_reg >= SIZE_W'(2)), 1'b0}
                      : {1'b1, 1'b1, (col_reg >= COL_W'(2))};
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                mask[i*3+j] = row_ok[i] & col_ok[j];
            end
        end
        wrap = ({1'b0, col_reg} + SIZE_W'(1)) >= size_reg;
    end

    always_comb begin
        size_next = size_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        if (cfg_we) begin
            size_next = clamp_size(cfg_wdata);
            row_next  = '0;
            col_next  = '0;
        end else if (proc) begin
            if (last) begin
                row_next = '0;
                col_next = '0;
            end else if (wrap) begin
                row_next = row_reg + SIZE_W'(1);
                col_next = '0;
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg    <= SIZE_W'(MAX_SIZE);
            row_reg     <= '0;
            col_reg     <= '0;
            a_valid_reg <= 1'b0;
        end else begin
            size_reg    <= size_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            a_valid_reg <= proc;
        end
    end

    assign eff_top = a_fwd_reg ? fwd_top_reg : up_q_reg;
    assign eff_mid = a_fwd_reg ? fwd_mid_reg : lo_q_reg;

    always_ff @(posedge aclk) begin
        up_q_reg <= upper_mem[col_reg];
        lo_q_reg <= lower_mem[col_reg];
        if (a_valid_reg) begin
            upper_mem[a_idx_reg] <= eff_mid;
            lower_mem[a_idx_reg] <= a_pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            a_idx_reg   <= col_reg;
            a_pix_reg   <= (row_reg < size_reg) ? pix_in : '0;
            a_col0_reg  <= col0;
            a_emit_reg  <= emit;
            a_last_reg  <= last;
            a_mask_reg  <= mask;
            a_fwd_reg   <= a_valid_reg && (a_idx_reg == col_reg);
            fwd_top_reg <= eff_mid;
            fwd_mid_reg <= a_pix_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win_next[i*3+0] = win_reg[i*3+1];
            win_next[i*3+1] = win_reg[i*3+2];
        end
        win_next[2] = eff_top;
        win_next[5] = eff_mid;
        win_next[8] = a_pix_reg;
    end

    always_ff @(posedge aclk) begin
        if (a_valid_reg) begin
            win_reg <= win_next;
        end
    end

    assign push           = a_valid_reg && a_emit_reg;
    assign push_data.px   = a_col0_reg ? win_reg : win_next;
    assign push_data.mask = a_mask_reg;
    assign push_data.last = a_last_reg;

endmodule

/* rtl/bb3_queue.sv */
// Short queue of classified windows between front and back ends.
module bb3_queue import bb3_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  bb3_item_t         push_data,
    input  logic              pop,
    output bb3_item_t         head,
    output logic              empty,
    output logic [QCNT_W-1:0] count
);

    bb3_item_t         q_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign head  = q_reg[rp_reg];
    assign empty = (cnt_reg == '0);
    assign count = cnt_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + QPTR_W'(1);
            end
            if (pop) begin
                rp_reg <= rp_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

endmodule

/* rtl/bb3_back.sv */
// Back end: masked window sums, reciprocal divide and output register.
module bb3_back import bb3_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  bb3_item_t  head,
    input  logic       empty,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [PIX_W-1:0] m_tdata,
    output logic       m_tlast
);

    logic ce;
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;

    logic [2:0][2:0][RSUM_W-1:0] rsum, s1_rsum_reg;
    logic [3:0]                  s1_cnt_reg;
    logic                        s1_last_reg;

    logic [2:0][TSUM_W-1:0]      s2_sum_reg;
    logic [RECIP_W-1:0]          s2_recip_reg;
    logic                        s2_last_reg;

    logic [2:0][PROD_W-1:0]      prod_reg;
    logic                        out_last_reg;

    assign ce  = !out_valid_reg || m_tready;
    assign pop = ce && !empty;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 3; i++) begin
                rsum[ch][i] = '0;
                for (int j = 0; j < 3; j++) begin
                    if (head.mask[i*3+j]) begin
                        rsum[ch][i] = rsum[ch][i]
                            + RSUM_W'(head.px[i*3+j][ch*CH_W +: CH_W]);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            s1_valid_reg  <= pop;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_rsum_reg  <= rsum;
            s1_cnt_reg   <= 4'($countones(head.mask));
            s1_last_reg  <= head.last;
            for (int ch = 0; ch < 3; ch++) begin
                s2_sum_reg[ch] <= TSUM_W'(s1_rsum_reg[ch][0]) + TSUM_W'(s1_rsum_reg[ch][1])
                                + TSUM_W'(s1_rsum_reg[ch][2]);
                prod_reg[ch]   <= PROD_W'(s2_sum_reg[ch]) * PROD_W'(s2_recip_reg);
            end
            s2_recip_reg <= recip(s1_cnt_reg);
            s2_last_reg  <= s1_last_reg;
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            m_tdata[ch*CH_W +: CH_W] = prod_reg[ch][RECIP_SH +: CH_W];
        end
    end

endmodule

/* verif/box_blur_3x3_clamped_tb.sv */
// Self-checking testbench for the streaming 3x3 box blur with clamped borders.
module box_blur_3x3_clamped_tb;
    import bb3_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic FN_PIXEL = 1'b0;
    localparam logic FN_FLUSH = 1'b1;

    typedef struct {
        logic [CH_W-1:0] r, g, b;
        logic            last;
    } blur_word_t;

    typedef struct {
        logic              do_cfg;
        logic [SIZE_W-1:0] size;
        logic              fn;
        logic [CH_W-1:0]   r, g, b;
        logic              typed;
        blur_word_t        want;
    } stim_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    logic [SIZE_W-1:0] cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [PIX_W-1:0]  s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [PIX_W-1:0]  m_tdata;
    logic              m_tlast;

    box_blur_3x3_clamped dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    blur_word_t blur_q[$];
    int         errors = 0;
    bit         calm = 1'b0;
    int         hold_req = 0;
    int         words_sent = 0;

    int   img_n;
    pix_t up_line[MAX_SIZE];
    pix_t lo_line[MAX_SIZE];
    pix_t win[9];
    int   in_r, in_c;

    function automatic void restart_frame();
        foreach (win[i]) win[i] = '0;
        in_r = 0;
        in_c = 0;
    endfunction

    function automatic blur_word_t window_mean(int row0, int col0, int ci, int cj);
        blur_word_t w;
        int sr, sg, sb, cnt;
        sr = 0; sg = 0; sb = 0; cnt = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (i < ci - 1 || i > ci + 1 || row0 + i < 0 || row0 + i >= img_n) continue;
                if (j < cj - 1 || j > cj + 1 || col0 + j < 0 || col0 + j >= img_n) continue;
                sr += win[i*3+j][CH_W-1:0];
                sg += win[i*3+j][2*CH_W-1:CH_W];
                sb += win[i*3+j][3*CH_W-1:2*CH_W];
                cnt++;
            end
        end
        if (cnt == 0) cnt = 1;
        w.r = CH_W'(sr / cnt);
        w.g = CH_W'(sg / cnt);
        w.b = CH_W'(sb / cnt);
        w.last = 1'b0;
        return w;
    endfunction

    function automatic bit blur_step(logic fn, pix_t din, output blur_word_t w);
        pix_t pix;
        int   orow, ocol, idx;
        bit   got;
        pix = '0; orow = -1; ocol = 0; got = 0; idx = in_c;
        if (fn == FN_FLUSH && in_r < img_n) return 0;
        if (in_r < img_n) pix = din;
        if (idx >= MAX_SIZE) idx = 0;
        if (in_c == 0) begin
            orow = in_r - 2;
            ocol = img_n - 1;
            if (orow >= 0 && orow < img_n) begin
                w = window_mean(in_r - 3, img_n - 3, 1, 2);
                got = 1;
            end
        end
        for (int i = 0; i < 3; i++) begin
            win[i*3] = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = up_line[idx];
        win[5] = lo_line[idx];
        win[8] = pix;
        up_line[idx] = lo_line[idx];
        lo_line[idx] = pix;
        if (in_c != 0) begin
            orow = in_r - 1;
            ocol = in_c - 1;
            if (orow >= 0 && orow < img_n) begin
                w = window_mean(in_r - 2, in_c - 2, 1, 1);
                got = 1;
            end
        end
        in_c++;
        if (in_c >= img_n) begin
            in_c = 0;
            in_r++;
        end
        if (!got) return 0;
        w.last = (orow == img_n - 1 && ocol == img_n - 1);
        if (w.last) restart_frame();
        return 1;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        blur_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (blur_q.size() == 0) begin
                report_mismatch("unexpected word", m_tdata, 0);
            end else begin
                w = blur_q.pop_front();
                if (m_tdata[CH_W-1:0] !== w.r)
                    report_mismatch("red", m_tdata[CH_W-1:0], w.r);
                if (m_tdata[2*CH_W-1:CH_W] !== w.g)
                    report_mismatch("green", m_tdata[2*CH_W-1:CH_W], w.g);
                if (m_tdata[3*CH_W-1:2*CH_W] !== w.b)
                    report_mismatch("blue", m_tdata[3*CH_W-1:2*CH_W], w.b);
                if (m_tlast !== w.last)
                    report_mismatch("tlast", m_tlast, w.last);
            end
        end
    end

    initial begin
        int hold_seen, hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 35);
            end
        end
    end

    task automatic write_size(logic [SIZE_W-1:0] v);
        wait (blur_q.size() == 0);
        repeat (20) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        img_n = (v == 0) ? 1 : (v > MAX_SIZE) ? MAX_SIZE : int'(v);
        restart_frame();
    endtask

    task automatic send_word(logic fn, logic [CH_W-1:0] r, g, b, bit typed, blur_word_t want);
        blur_word_t w;
        if (!calm) begin
            while ($urandom_range(99) < 35) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {b, g, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        if (blur_step(fn, {b, g, r}, w)) blur_q.push_back(typed ? want : w);
    endtask

    task automatic send_random(logic fn);
        blur_word_t dummy;
        send_word(fn, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom), 0, dummy);
    endtask

    localparam blur_word_t W_MAX  = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1};
    localparam blur_word_t W_ZERO = '{16'h0000, 16'h0000, 16'h0000, 1'b1};
    localparam blur_word_t W_NONE = '{16'h0000, 16'h0000, 16'h0000, 1'b0};

    stim_row_t directed[] = '{
        '{1, 11'd0,    FN_FLUSH, 16'h1234, 16'h5678, 16'h9ABC, 0, W_NONE},
        '{0, 11'd0,    FN_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, W_NONE},
        '{0, 11'd0,    FN_PIXEL, 16'h1111, 16'h2222, 16'h3333, 0, W_NONE},
        '{0, 11'd0,    FN_FLUSH, 16'h0000, 16'h0000, 16'h0000, 1, W_MAX},
        '{0, 11'd0,    FN_PIXEL, 16'h0000, 16'h0000, 16'h0000, 0, W_NONE},
        '{0, 11'd0,    FN_FLUSH, 16'h0000, 16'h0000, 16'h0000, 0, W_NONE},
        '{0, 11'd0,    FN_FLUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, W_ZERO},
        '{1, 11'd2,    FN_PIXEL, 16'hFFFF, 16'h0000, 16'h8001, 0, W_NONE},
        '{0, 11'd0,    FN_FLUSH, 16'h0000, 16'h0000, 16'h0000, 0, W_NONE},
        '{0, 11'd0,    FN_PIXEL, 16'h0001, 16'hFFFF, 16'h7FFE, 0, W_NONE},
        '{0, 11'd0,    FN_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, W_NONE},
        '{0, 11'd0,    FN_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, W_NONE},
        '{0, 11'd0,    FN_FLUSH, 16'h0000, 16'h0000, 16'h0000, 0, W_NONE},
        '{0, 11'd0,    FN_PIXEL, 16'h4321, 16'h0000, 16'h0000, 0, W_NONE},
        '{0, 11'd0,    FN_FLUSH, 16'h0000, 16'h0000, 16'h0000, 0, W_NONE},
        '{1, 11'd3,    FN_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, W_NONE},
        '{0, 11'd0,    FN_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, W_NONE},
        '{0, 11'd0,    FN_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, W_NONE},
        '{0, 11'd0,    FN_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, W_NONE},
        '{1, 11'd2047, FN_PIXEL, 16'hAAAA, 16'h5555, 16'hFFFF, 0, W_NONE}
    };

    initial begin
        int n, len;
        img_n = MAX_SIZE;
        foreach (up_line[i]) begin
            up_line[i] = '0;
            lo_line[i] = '0;
        end
        restart_frame();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset size: first row and the start of the second row of a full-width frame, then restart
        for (int k = 0; k < MAX_SIZE + 4; k++) send_random(FN_PIXEL);
        s_tvalid <= 1'b0;

        foreach (directed[i]) begin
            if (directed[i].do_cfg) begin
                s_tvalid <= 1'b0;
                write_size(directed[i].size);
            end
            send_word(directed[i].fn, directed[i].r, directed[i].g, directed[i].b,
                      directed[i].typed, directed[i].want);
        end
        for (int k = 0; k < 8; k++) send_random(FN_PIXEL);
        s_tvalid <= 1'b0;

        for (int f = 0; words_sent < 1850; f++) begin
            calm = (f >= 4 && f < 8);
            n = ($urandom_range(99) < 80) ? $urandom_range(6, 1) : $urandom_range(16, 7);
            if (f == 1) n = 16;
            s_tvalid <= 1'b0;
            write_size(SIZE_W'(n));
            if (f == 1) hold_req++;
            len = (f != 1 && $urandom_range(99) < 8) ? $urandom_range(n * n) : n * n + n + 1;
            for (int k = 0; k < len; k++) begin
                if (k < n * n) begin
                    if ($urandom_range(99) < 4) send_random(FN_FLUSH);
                    send_random(FN_PIXEL);
                end else begin
                    send_random(($urandom_range(99) < 15) ? FN_PIXEL : FN_FLUSH);
                end
            end
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;
        wait (blur_q.size() == 0);
        repeat (30) @(posedge aclk);
        if (errors == 0) begin
            $display("box_blur_3x3_clamped test passed");
        end else begin
            $display("box_blur_3x3_clamped test failed");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("box_blur_3x3_clamped test failed");
        $finish;
    end

endmodule

/* files.f */
rtl/bb3_pkg.sv
rtl/bb3_front.sv
rtl/bb3_queue.sv
rtl/bb3_back.sv
rtl/box_blur_3x3_clamped.sv
verif/box_blur_3x3_clamped_tb.sv
